// ===== design/swo_pkg.sv =====
// shared types, fixed-point constants and lookup functions for the swerve odometry block
package swo_pkg;

	localparam int NUM_WHEELS   = 4;
	localparam int QUEUE_DEPTH  = 2;
	localparam int CORDIC_STEPS = 24;

	localparam logic [17:0] DIAG_WIDTH_RESET = 18'd28836;

	localparam logic signed [33:0] Q30_PI          = 34'sd3373259426;
	localparam logic signed [33:0] Q30_HALF_PI     = 34'sd1686629713;
	localparam logic signed [33:0] Q30_QUARTER_PI  = 34'sd843314856;
	localparam logic signed [33:0] Q30_3QUARTER_PI = 34'sd2529944570;
	localparam logic signed [55:0] Q30_CORDIC_GAIN = 56'sd652032874;

	typedef enum logic {
		CMD_REPORT  = 1'b0,
		CMD_PUBLISH = 1'b1
	} cmd_t;

	// one queued item, steering angle already folded into +/- pi/2
	typedef struct packed {
		cmd_t               cmd;
		logic [1:0]         wheel;
		logic signed [23:0] speed;
		logic signed [33:0] ang;
		logic               neg;
		logic [19:0]        dt;
	} item_t;

	typedef struct packed {
		logic busy;
		logic publishing;
	} back_stat_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'h3243F6A8;
			5'd1:  r = 30'h1DAC6705;
			5'd2:  r = 30'h0FADBAFC;
			5'd3:  r = 30'h07F56EA6;
			5'd4:  r = 30'h03FEAB76;
			5'd5:  r = 30'h01FFD55B;
			5'd6:  r = 30'h00FFFAAA;
			5'd7:  r = 30'h007FFF55;
			5'd8:  r = 30'h003FFFEA;
			5'd9:  r = 30'h001FFFFD;
			5'd10: r = 30'h000FFFFF;
			5'd11: r = 30'h0007FFFF;
			5'd12: r = 30'h0003FFFF;
			5'd13: r = 30'h0001FFFF;
			5'd14: r = 30'h0000FFFF;
			5'd15: r = 30'h00007FFF;
			5'd16: r = 30'h00003FFF;
			5'd17: r = 30'h00001FFF;
			5'd18: r = 30'h00000FFF;
			5'd19: r = 30'h000007FF;
			5'd20: r = 30'h000003FF;
			5'd21: r = 30'h000001FF;
			5'd22: r = 30'h000000FF;
			5'd23: r = 30'h0000007F;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

	// nominal diagonal of each position in the heading sum
	function automatic logic signed [33:0] diag_offset(input logic [1:0] i);
		logic signed [33:0] r;
		case (i)
			2'd0:    r = -Q30_QUARTER_PI;
			2'd1:    r = -Q30_3QUARTER_PI;
			2'd2:    r = Q30_3QUARTER_PI;
			2'd3:    r = Q30_QUARTER_PI;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/swerve_wheel_odometry.sv =====
// top level of the swerve wheel odometry block
// Usage:
//   Input channel: drive the item fields and raise push; the item is taken at a clock
//   edge with push high and full low. command 0 is a wheel report that moves one
//   corner, command 1 is a publish that produces one result.
//   Result channel: while empty is low the oldest result sits on the result ports;
//   raise pop to take it.
//   cfg_we/cfg_wdata load the diagonal width and reload all four corners; write only
//   while the block is idle.
// Engine work:
//   A wheel report holds the engine for 24 CORDIC rotations and two split 44x18
//   multiplies over the shared 25x25 multiplier.
//   A publish runs four 24-step CORDIC vectoring runs and three 53-step radix-2
//   divisions for the rates; zero elapsed time skips the divisions and a corner at
//   the center skips its CORDIC run.
//   A two-entry input queue keeps accepting items while the engine works or while a
//   finished result waits; a publish that finishes while the result register is
//   still full holds the engine until the result is popped.
// Reset: arst_n clears the queues and restores the corners to +/- half of the
//   default diagonal width and the previous pose to zero.
module swerve_wheel_odometry #(
	parameter int QUEUE_DEPTH = swo_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               command,
	input  logic [1:0]         wheel_index,
	input  logic signed [23:0] wheel_speed,
	input  logic signed [15:0] steer_angle,
	input  logic [19:0]        elapsed_time,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] center_x,
	output logic signed [31:0] center_y,
	output logic signed [15:0] heading,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] yaw_rate,
	input  logic               cfg_we,
	input  logic [17:0]        cfg_wdata
);

	swo_pkg::item_t      q_item;
	logic                q_valid;
	logic                q_take;
	swo_pkg::back_stat_t stat;

	swo_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.wheel_index  (wheel_index),
		.wheel_speed  (wheel_speed),
		.steer_angle  (steer_angle),
		.elapsed_time (elapsed_time),
		.q_item       (q_item),
		.q_valid      (q_valid),
		.q_take       (q_take)
	);

	swo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.empty     (empty),
		.pop       (pop),
		.center_x  (center_x),
		.center_y  (center_y),
		.heading   (heading),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.yaw_rate  (yaw_rate),
		.stat      (stat)
	);

	// the engine only takes an item that the queue holds
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("engine took an item from an empty queue");

	// a taken item always starts work
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> stat.busy)
		else $error("engine stayed idle after taking an item");

	// a result appears only at the end of engine work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(stat.busy))
		else $error("result appeared without a publish in progress");

	// publish steps are part of engine work
	a_publish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.publishing |-> stat.busy)
		else $error("publish step outside engine work");

endmodule

// ===== design/swo_front.sv =====
// input queue: accepts items, folds the steering angle and buffers them for the engine
module swo_front #(
	parameter int DEPTH = swo_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                command,
	input  logic [1:0]          wheel_index,
	input  logic signed [23:0]  wheel_speed,
	input  logic signed [15:0]  steer_angle,
	input  logic [19:0]         elapsed_time,
	output swo_pkg::item_t      q_item,
	output logic                q_valid,
	input  logic                q_take
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	swo_pkg::item_t     mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	swo_pkg::item_t     item_in;
	logic signed [33:0] ang_raw;
	logic               do_push;
	logic               do_pop;

	assign ang_raw = {steer_angle[15], steer_angle, 17'b0};

	// bring the angle into +/- pi/2, remembering the sign flip
	always_comb begin
		item_in.cmd   = swo_pkg::cmd_t'(command);
		item_in.wheel = wheel_index;
		item_in.speed = wheel_speed;
		item_in.dt    = elapsed_time;
		item_in.ang   = ang_raw;
		item_in.neg   = 1'b0;
		if (ang_raw > swo_pkg::Q30_HALF_PI) begin
			item_in.ang = ang_raw - swo_pkg::Q30_PI;
			item_in.neg = 1'b1;
		end else if (ang_raw < -swo_pkg::Q30_HALF_PI) begin
			item_in.ang = ang_raw + swo_pkg::Q30_PI;
			item_in.neg = 1'b1;
		end
	end

	assign full    = (cnt_q == CW'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = q_take & q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

// ===== design/swo_back.sv =====
// engine: corner dead reckoning, center, heading and rate computation, result register
module swo_back (
	input  logic                clk,
	input  logic                arst_n,
	input  swo_pkg::item_t      q_item,
	input  logic                q_valid,
	output logic                q_take,
	input  logic                cfg_we,
	input  logic [17:0]         cfg_wdata,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  center_x,
	output logic signed [31:0]  center_y,
	output logic signed [15:0]  heading,
	output logic signed [31:0]  vel_x,
	output logic signed [31:0]  vel_y,
	output logic signed [31:0]  yaw_rate,
	output swo_pkg::back_stat_t stat
);

	typedef enum logic [19:0] {
		ST_IDLE = 20'h00001,
		ST_DIST = 20'h00002,
		ST_CORD = 20'h00004,
		ST_SC   = 20'h00008,
		ST_ML   = 20'h00010,
		ST_MH   = 20'h00020,
		ST_MA   = 20'h00040,
		ST_UPD  = 20'h00080,
		ST_SUM  = 20'h00100,
		ST_CEN  = 20'h00200,
		ST_REL  = 20'h00400,
		ST_VSET = 20'h00800,
		ST_ACC  = 20'h01000,
		ST_THR  = 20'h02000,
		ST_THQ  = 20'h04000,
		ST_HD   = 20'h08000,
		ST_DSET = 20'h10000,
		ST_DIV  = 20'h20000,
		ST_DEND = 20'h40000,
		ST_FIN  = 20'h80000
	} state_t;

	localparam logic [1:0] RATE_X   = 2'd0;
	localparam logic [1:0] RATE_Y   = 2'd1;
	localparam logic [1:0] RATE_YAW = 2'd2;

	localparam logic [5:0] CORD_LAST = 6'(swo_pkg::CORDIC_STEPS - 1);
	localparam logic [5:0] DIV_LAST  = 6'd52;
	localparam logic [5:0] WHL_LAST  = 6'(swo_pkg::NUM_WHEELS - 1);

	state_t             state_q;
	swo_pkg::item_t     it_q;
	logic [5:0]         cnt_q;
	logic               vec_q;
	logic               ax_q;
	logic [1:0]         pos_q;
	logic [1:0]         start_q;
	logic               found_q;
	logic [1:0]         rsel_q;
	logic               out_valid_q;

	logic [31:0]        cor_x_q [swo_pkg::NUM_WHEELS];
	logic [31:0]        cor_y_q [swo_pkg::NUM_WHEELS];
	logic [31:0]        prev_x_q;
	logic [31:0]        prev_y_q;
	logic [15:0]        prev_h_q;

	logic signed [55:0] x_q;
	logic signed [55:0] y_q;
	logic signed [33:0] z_q;
	logic signed [43:0] dist_q;
	logic signed [17:0] sc_s_q;
	logic signed [17:0] sc_c_q;
	logic signed [49:0] mp_q;
	logic signed [63:0] acc_q;
	logic signed [33:0] sx_q;
	logic signed [33:0] sy_q;
	logic signed [31:0] cen_x_q;
	logic signed [31:0] cen_y_q;
	logic signed [32:0] px_q [swo_pkg::NUM_WHEELS];
	logic signed [32:0] py_q [swo_pkg::NUM_WHEELS];
	logic signed [35:0] th_sum_q;
	logic signed [33:0] thr_q;
	logic signed [34:0] quad_q;
	logic signed [34:0] th2_q;
	logic signed [15:0] hd_q;
	logic [52:0]        dvd_q;
	logic [20:0]        rem_q;
	logic               dneg_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;
	logic signed [31:0] yr_q;
	logic signed [31:0] res_cx_q;
	logic signed [31:0] res_cy_q;
	logic signed [15:0] res_hd_q;
	logic signed [31:0] res_vx_q;
	logic signed [31:0] res_vy_q;
	logic signed [31:0] res_yr_q;

	// shared multiplier
	logic signed [24:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [17:0] sc_sel;

	// cordic step
	logic signed [55:0] xs;
	logic signed [55:0] ys;
	logic signed [33:0] atan_v;
	logic               dir;

	logic signed [55:0] rnd_s;
	logic signed [55:0] rnd_c;
	logic signed [17:0] s_val;
	logic signed [17:0] c_val;
	logic signed [63:0] rnd_acc;
	logic [31:0]        delta;
	logic [1:0]         widx;

	logic signed [32:0] rel_x;
	logic signed [32:0] rel_y;
	logic               rel_hit;
	logic [1:0]         kidx;
	logic signed [55:0] vx56;
	logic signed [55:0] vy56;
	logic               vzero;
	logic signed [33:0] diag_v;

	logic signed [33:0] cen_rx;
	logic signed [33:0] cen_ry;
	logic signed [35:0] thr_full;
	logic signed [33:0] u_v;
	logic signed [33:0] v_v;
	logic signed [34:0] quad_v;
	logic signed [34:0] hd_full;
	logic signed [15:0] hd_sat;

	logic signed [32:0] dif_a;
	logic signed [32:0] dif_b;
	logic signed [32:0] dif;
	logic [32:0]        dif_mag;
	logic [20:0]        rsh;
	logic               ge;
	logic signed [31:0] div_sat;
	logic               store_rate;
	logic signed [31:0] rate_val;
	logic [31:0]        half_bw;

	assign q_take = (state_q == ST_IDLE) && q_valid;
	assign empty  = ~out_valid_q;
	assign stat.busy       = (state_q != ST_IDLE);
	assign stat.publishing = state_q inside {ST_SUM, ST_FIN};

	assign center_x = res_cx_q;
	assign center_y = res_cy_q;
	assign heading  = res_hd_q;
	assign vel_x    = res_vx_q;
	assign vel_y    = res_vy_q;
	assign yaw_rate = res_yr_q;

	assign widx    = it_q.wheel;
	assign half_bw = {15'b0, cfg_wdata[17:1]};

	always_comb begin
		sc_sel = ax_q ? sc_c_q : sc_s_q;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_DIST: begin
				mul_a = {it_q.speed[23], it_q.speed};
				mul_b = {5'b0, it_q.dt};
			end
			ST_ML: begin
				mul_a = {3'b0, dist_q[21:0]};
				mul_b = {{7{sc_sel[17]}}, sc_sel};
			end
			ST_MH: begin
				mul_a = {{3{dist_q[43]}}, dist_q[43:22]};
				mul_b = {{7{sc_sel[17]}}, sc_sel};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// rotation mode drives z to zero, vectoring mode drives y to zero
	assign xs     = x_q >>> cnt_q[4:0];
	assign ys     = y_q >>> cnt_q[4:0];
	assign atan_v = {4'b0, swo_pkg::atan_q30(cnt_q[4:0])};
	assign dir    = vec_q ? !(y_q > 56'sd0) : (z_q >= 34'sd0);

	// round to nearest, ties away from zero
	assign rnd_s = (y_q + (y_q[55] ? 56'sd8191 : 56'sd8192)) >>> 14;
	assign rnd_c = (x_q + (x_q[55] ? 56'sd8191 : 56'sd8192)) >>> 14;
	assign s_val = it_q.neg ? -rnd_s[17:0] : rnd_s[17:0];
	assign c_val = it_q.neg ? -rnd_c[17:0] : rnd_c[17:0];
	assign rnd_acc = (acc_q + (acc_q[63] ? 64'sd34359738367 : 64'sd34359738368)) >>> 36;
	assign delta   = rnd_acc[31:0];

	assign cen_rx = (sx_q + (sx_q[33] ? 34'sd1 : 34'sd2)) >>> 2;
	assign cen_ry = (sy_q + (sy_q[33] ? 34'sd1 : 34'sd2)) >>> 2;

	assign rel_x   = {cor_x_q[cnt_q[1:0]][31], cor_x_q[cnt_q[1:0]]} - {cen_x_q[31], cen_x_q};
	assign rel_y   = {cor_y_q[cnt_q[1:0]][31], cor_y_q[cnt_q[1:0]]} - {cen_y_q[31], cen_y_q};
	assign rel_hit = (rel_x > 33'sd0) && (rel_y >= 33'sd0);

	assign kidx   = start_q + pos_q;
	assign vx56   = {{3{px_q[kidx][32]}}, px_q[kidx], 20'b0};
	assign vy56   = {{3{py_q[kidx][32]}}, py_q[kidx], 20'b0};
	assign vzero  = (px_q[kidx] == 33'sd0) && (py_q[kidx] == 33'sd0);
	assign diag_v = swo_pkg::diag_offset(pos_q);

	assign thr_full = (th_sum_q + (th_sum_q[35] ? 36'sd1 : 36'sd2)) >>> 2;
	assign u_v = {py_q[0][32], py_q[0]} + {px_q[0][32], px_q[0]};
	assign v_v = {py_q[0][32], py_q[0]} - {px_q[0][32], px_q[0]};

	// quadrant from wheel 0 turned by -45 degrees
	always_comb begin
		quad_v = '0;
		if (u_v > 34'sd0 && v_v >= 34'sd0) begin
			quad_v = '0;
		end else if (u_v <= 34'sd0 && v_v > 34'sd0) begin
			quad_v = 35'(swo_pkg::Q30_HALF_PI);
		end else if (u_v < 34'sd0 && v_v <= 34'sd0) begin
			quad_v = -35'(swo_pkg::Q30_PI);
		end else if (u_v >= 34'sd0 && v_v < 34'sd0) begin
			quad_v = -35'(swo_pkg::Q30_HALF_PI);
		end
	end

	assign hd_full = (th2_q + (th2_q[34] ? 35'sd65535 : 35'sd65536)) >>> 17;
	always_comb begin
		if (hd_full > 35'sd32767) begin
			hd_sat = 16'sh7FFF;
		end else if (hd_full < -35'sd32768) begin
			hd_sat = 16'sh8000;
		end else begin
			hd_sat = hd_full[15:0];
		end
	end

	always_comb begin
		case (rsel_q)
			RATE_X: begin
				dif_a = {cen_x_q[31], cen_x_q};
				dif_b = {prev_x_q[31], prev_x_q};
			end
			RATE_Y: begin
				dif_a = {cen_y_q[31], cen_y_q};
				dif_b = {prev_y_q[31], prev_y_q};
			end
			default: begin
				dif_a = {{17{hd_q[15]}}, hd_q};
				dif_b = {{17{prev_h_q[15]}}, prev_h_q};
			end
		endcase
		dif     = dif_a - dif_b;
		dif_mag = dif[32] ? 33'(-dif) : 33'(dif);
	end

	assign rsh = {rem_q[19:0], dvd_q[52]};
	assign ge  = (rsh >= {1'b0, it_q.dt});

	always_comb begin
		if (dneg_q) begin
			div_sat = (dvd_q > 53'h80000000) ? 32'sh80000000 : -dvd_q[31:0];
		end else begin
			div_sat = (dvd_q > 53'h7FFFFFFF) ? 32'sh7FFFFFFF : dvd_q[31:0];
		end
	end

	assign store_rate = (state_q == ST_DEND) ||
		((state_q == ST_DSET) && (it_q.dt == 20'd0));
	assign rate_val   = (state_q == ST_DEND) ? div_sat : 32'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			vec_q       <= 1'b0;
			ax_q        <= 1'b0;
			pos_q       <= '0;
			start_q     <= '0;
			found_q     <= 1'b0;
			rsel_q      <= RATE_X;
			out_valid_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_h_q    <= '0;
			cor_x_q[0]  <= {15'b0, swo_pkg::DIAG_WIDTH_RESET[17:1]};
			cor_y_q[0]  <= {15'b0, swo_pkg::DIAG_WIDTH_RESET[17:1]};
			cor_x_q[1]  <= -{15'b0, swo_pkg::DIAG_WIDTH_RESET[17:1]};
			cor_y_q[1]  <= {15'b0, swo_pkg::DIAG_WIDTH_RESET[17:1]};
			cor_x_q[2]  <= -{15'b0, swo_pkg::DIAG_WIDTH_RESET[17:1]};
			cor_y_q[2]  <= -{15'b0, swo_pkg::DIAG_WIDTH_RESET[17:1]};
			cor_x_q[3]  <= {15'b0, swo_pkg::DIAG_WIDTH_RESET[17:1]};
			cor_y_q[3]  <= -{15'b0, swo_pkg::DIAG_WIDTH_RESET[17:1]};
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				cor_x_q[0] <= half_bw;
				cor_y_q[0] <= half_bw;
				cor_x_q[1] <= -half_bw;
				cor_y_q[1] <= half_bw;
				cor_x_q[2] <= -half_bw;
				cor_y_q[2] <= -half_bw;
				cor_x_q[3] <= half_bw;
				cor_y_q[3] <= -half_bw;
			end else if (state_q == ST_UPD) begin
				if (!ax_q) begin
					cor_x_q[widx] <= cor_x_q[widx] - delta;
				end else begin
					cor_y_q[widx] <= cor_y_q[widx] + delta;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= (q_item.cmd == swo_pkg::CMD_PUBLISH) ? ST_SUM : ST_DIST;
						cnt_q   <= '0;
						ax_q    <= 1'b0;
					end
				end
				ST_DIST: begin
					cnt_q   <= '0;
					vec_q   <= 1'b0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CORD_LAST) begin
						state_q <= vec_q ? ST_ACC : ST_SC;
					end
				end
				ST_SC: state_q <= ST_ML;
				ST_ML: state_q <= ST_MH;
				ST_MH: state_q <= ST_MA;
				ST_MA: state_q <= ST_UPD;
				ST_UPD: begin
					if (!ax_q) begin
						ax_q    <= 1'b1;
						state_q <= ST_ML;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == WHL_LAST) begin
						state_q <= ST_CEN;
					end
				end
				ST_CEN: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					start_q <= '0;
					state_q <= ST_REL;
				end
				ST_REL: begin
					cnt_q <= cnt_q + 1'b1;
					if (rel_hit && !found_q) begin
						start_q <= cnt_q[1:0];
						found_q <= 1'b1;
					end
					if (cnt_q == WHL_LAST) begin
						pos_q   <= '0;
						state_q <= ST_VSET;
					end
				end
				ST_VSET: begin
					if (vzero) begin
						state_q <= ST_ACC;
					end else begin
						cnt_q   <= '0;
						vec_q   <= 1'b1;
						state_q <= ST_CORD;
					end
				end
				ST_ACC: begin
					pos_q <= pos_q + 1'b1;
					state_q <= (pos_q == 2'd3) ? ST_THR : ST_VSET;
				end
				ST_THR: state_q <= ST_THQ;
				ST_THQ: state_q <= ST_HD;
				ST_HD: begin
					rsel_q  <= RATE_X;
					state_q <= ST_DSET;
				end
				ST_DSET: begin
					cnt_q <= '0;
					if (it_q.dt == 20'd0) begin
						if (rsel_q == RATE_YAW) begin
							state_q <= ST_FIN;
						end else begin
							rsel_q <= rsel_q + 1'b1;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_DEND;
					end
				end
				ST_DEND: begin
					if (rsel_q == RATE_YAW) begin
						state_q <= ST_FIN;
					end else begin
						rsel_q  <= rsel_q + 1'b1;
						state_q <= ST_DSET;
					end
				end
				ST_FIN: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						prev_x_q    <= cen_x_q;
						prev_y_q    <= cen_y_q;
						prev_h_q    <= hd_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (store_rate) begin
			case (rsel_q)
				RATE_X:  vx_q <= rate_val;
				RATE_Y:  vy_q <= rate_val;
				default: yr_q <= rate_val;
			endcase
		end
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					it_q     <= q_item;
					sx_q     <= '0;
					sy_q     <= '0;
					th_sum_q <= '0;
				end
			end
			ST_DIST: begin
				dist_q <= mul_p[43:0];
				x_q    <= swo_pkg::Q30_CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= it_q.ang;
			end
			ST_CORD: begin
				if (dir) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_v;
				end
			end
			ST_SC: begin
				sc_s_q <= s_val;
				sc_c_q <= c_val;
			end
			ST_ML: mp_q <= mul_p;
			ST_MH: begin
				acc_q <= {{14{mp_q[49]}}, mp_q};
				mp_q  <= mul_p;
			end
			ST_MA: acc_q <= acc_q + ({{14{mp_q[49]}}, mp_q} <<< 22);
			ST_SUM: begin
				sx_q <= sx_q + {{2{cor_x_q[cnt_q[1:0]][31]}}, cor_x_q[cnt_q[1:0]]};
				sy_q <= sy_q + {{2{cor_y_q[cnt_q[1:0]][31]}}, cor_y_q[cnt_q[1:0]]};
			end
			ST_CEN: begin
				cen_x_q <= cen_rx[31:0];
				cen_y_q <= cen_ry[31:0];
			end
			ST_REL: begin
				px_q[cnt_q[1:0]] <= rel_x;
				py_q[cnt_q[1:0]] <= rel_y;
			end
			ST_VSET: begin
				if (vzero) begin
					z_q <= '0;
				end else if (vx56 < 56'sd0) begin
					if (vy56 >= 56'sd0) begin
						x_q <= vy56;
						y_q <= -vx56;
						z_q <= swo_pkg::Q30_HALF_PI;
					end else begin
						x_q <= -vy56;
						y_q <= vx56;
						z_q <= -swo_pkg::Q30_HALF_PI;
					end
				end else begin
					x_q <= vx56;
					y_q <= vy56;
					z_q <= '0;
				end
			end
			ST_ACC: begin
				th_sum_q <= th_sum_q + {{2{z_q[33]}}, z_q} + {{2{diag_v[33]}}, diag_v};
			end
			ST_THR: begin
				thr_q  <= thr_full[33:0];
				quad_q <= quad_v;
			end
			ST_THQ: th2_q <= {thr_q[33], thr_q} + quad_q;
			ST_HD:  hd_q <= hd_sat;
			ST_DSET: begin
				rem_q  <= '0;
				dneg_q <= dif[32];
				dvd_q  <= (rsel_q == RATE_YAW) ? (53'(dif_mag) << 23) : (53'(dif_mag) << 20);
			end
			ST_DIV: begin
				rem_q <= ge ? (rsh - {1'b0, it_q.dt}) : rsh;
				dvd_q <= {dvd_q[51:0], ge};
			end
			ST_FIN: begin
				if (!out_valid_q) begin
					res_cx_q <= cen_x_q;
					res_cy_q <= cen_y_q;
					res_hd_q <= hd_q;
					res_vx_q <= vx_q;
					res_vy_q <= vy_q;
					res_yr_q <= yr_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/tb_swerve_wheel_odometry.sv =====
// self-checking testbench for the swerve wheel odometry block
module tb_swerve_wheel_odometry;

	localparam int  CYCLE_LIMIT  = 3000000;
	localparam int  SETTLE_CYCLES = 800;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [15:0] hd;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] yr;
	} pose_t;

	class odom_scoreboard;
		localparam longint PI_Q30 = 64'sd3373259426;
		localparam longint HALF_PI_Q30 = 64'sd1686629713;
		localparam longint QTR_PI_Q30 = 64'sd843314856;
		localparam longint TQTR_PI_Q30 = 64'sd2529944570;
		localparam longint GAIN_Q30 = 64'sd652032874;

		longint             atan_tab[24];
		longint             diag[4];
		logic [17:0]        width;
		logic signed [31:0] corner_x[4];
		logic signed [31:0] corner_y[4];
		logic signed [31:0] last_cx, last_cy;
		logic signed [15:0] last_hd;
		pose_t              pose_q[$];

		function new();
			atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
				64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
				64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
				64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
				64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
			diag = '{-QTR_PI_Q30, -TQTR_PI_Q30, TQTR_PI_Q30, QTR_PI_Q30};
			last_cx = '0;
			last_cy = '0;
			last_hd = '0;
			configure(swo_pkg::DIAG_WIDTH_RESET);
		endfunction

		function void configure(logic [17:0] w);
			logic signed [31:0] h;
			width = w;
			h = 32'(w >> 1);
			corner_x = '{h, -h, -h, h};
			corner_y = '{h, h, -h, -h};
		endfunction

		function longint round_sh(longint v, int s);
			longint h;
			h = longint'(1) << (s - 1);
			return v < 0 ? -((-v + h) >>> s) : (v + h) >>> s;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void sin_cos(input longint a, output longint s, output longint c);
			logic   flip;
			longint x, y, z, xs, ys;
			flip = 1'b0;
			x = GAIN_Q30;
			y = 0;
			if (a > HALF_PI_Q30) begin
				a -= PI_Q30;
				flip = 1'b1;
			end else if (a < -HALF_PI_Q30) begin
				a += PI_Q30;
				flip = 1'b1;
			end
			z = a;
			for (int i = 0; i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_tab[i];
				end else begin
					x += ys; y -= xs; z += atan_tab[i];
				end
			end
			s = round_sh(y, 14);
			c = round_sh(x, 14);
			if (flip) begin
				s = -s;
				c = -c;
			end
		endfunction

		function longint vector_angle(longint x, longint y);
			longint z, t, xs, ys;
			z = 0;
			if (x == 0 && y == 0)
				return 0;
			x = x * (longint'(1) << 20);
			y = y * (longint'(1) << 20);
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = HALF_PI_Q30;
				end else begin
					t = x; x = -y; y = t; z = -HALF_PI_Q30;
				end
			end
			for (int i = 0; i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys; y -= xs; z += atan_tab[i];
				end else begin
					x -= ys; y += xs; z -= atan_tab[i];
				end
			end
			return z;
		endfunction

		function longint rate_of(longint diff, longint scale, longint dt);
			if (dt == 0)
				return 0;
			return clamp(diff * scale / dt, -64'sd2147483648, 64'sd2147483647);
		endfunction

		function void note_item(swo_pkg::cmd_t cmd, logic [1:0] w, logic signed [23:0] spd,
				logic signed [15:0] ang, logic [19:0] dt);
			longint s, c, travel, cx, cy, th, u, v, hd;
			longint px[4], py[4];
			int     first;
			pose_t  p;
			if (cmd == swo_pkg::CMD_REPORT) begin
				travel = longint'(spd) * longint'(dt);
				sin_cos(longint'(ang) * (longint'(1) << 17), s, c);
				corner_x[w] = corner_x[w] - 32'(round_sh(travel * s, 36));
				corner_y[w] = corner_y[w] + 32'(round_sh(travel * c, 36));
				return;
			end
			cx = 0;
			cy = 0;
			for (int i = 0; i < 4; i++) begin
				cx += longint'(corner_x[i]);
				cy += longint'(corner_y[i]);
			end
			cx = round_sh(cx, 2);
			cy = round_sh(cy, 2);
			first = 0;
			for (int i = 0; i < 4; i++) begin
				px[i] = longint'(corner_x[i]) - cx;
				py[i] = longint'(corner_y[i]) - cy;
			end
			// lowest-numbered corner in the first quadrant leads the sum
			for (int i = 3; i >= 0; i--)
				if (px[i] > 0 && py[i] >= 0)
					first = i;
			th = 0;
			for (int i = 0; i < 4; i++)
				th += vector_angle(px[(first + i) % 4], py[(first + i) % 4]) + diag[i];
			th = round_sh(th, 2);
			// quadrant from wheel 0 turned by -45 degrees
			u = px[0] + py[0];
			v = py[0] - px[0];
			if (u > 0 && v >= 0) begin
			end else if (u <= 0 && v > 0) begin
				th += HALF_PI_Q30;
			end else if (u < 0 && v <= 0) begin
				th -= PI_Q30;
			end else if (u >= 0 && v < 0) begin
				th -= HALF_PI_Q30;
			end
			hd = clamp(round_sh(th, 17), -32768, 32767);
			p.cx = 32'(cx);
			p.cy = 32'(cy);
			p.hd = 16'(hd);
			p.vx = 32'(rate_of(cx - longint'(last_cx), longint'(1) << 20, longint'(dt)));
			p.vy = 32'(rate_of(cy - longint'(last_cy), longint'(1) << 20, longint'(dt)));
			p.yr = 32'(rate_of(hd - longint'(last_hd), longint'(1) << 23, longint'(dt)));
			pose_q.push_back(p);
			last_cx = p.cx;
			last_cy = p.cy;
			last_hd = p.hd;
		endfunction

		// bit 6 flags a result with nothing expected, bits 5..0 the fields
		function logic [6:0] check(pose_t got);
			pose_t e;
			if (pose_q.size() == 0)
				return 7'b1000000;
			e = pose_q.pop_front();
			return {1'b0, got.cx != e.cx, got.cy != e.cy, got.hd != e.hd,
				got.vx != e.vx, got.vy != e.vy, got.yr != e.yr};
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic               command;
	logic [1:0]         wheel_index;
	logic signed [23:0] wheel_speed;
	logic signed [15:0] steer_angle;
	logic [19:0]        elapsed_time;
	logic               empty;
	logic               pop;
	logic signed [31:0] center_x, center_y, vel_x, vel_y, yaw_rate;
	logic signed [15:0] heading;
	logic               cfg_we;
	logic [17:0]        cfg_wdata;

	odom_scoreboard sb;
	int             errors;
	int             cycles;
	int             pop_hold;

	swerve_wheel_odometry u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.wheel_index(wheel_index), .wheel_speed(wheel_speed), .steer_angle(steer_angle),
		.elapsed_time(elapsed_time), .empty(empty), .pop(pop), .center_x(center_x),
		.center_y(center_y), .heading(heading), .vel_x(vel_x), .vel_y(vel_y),
		.yaw_rate(yaw_rate), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report(string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random pop stalls, mostly short
	always @(posedge clk) begin
		logic [6:0] bad;
		if (arst_n && pop && !empty) begin
			bad = sb.check('{center_x, center_y, heading, vel_x, vel_y, yaw_rate});
			if (bad[6]) report("result with nothing expected");
			if (bad[5]) report($sformatf("center_x %0d", center_x));
			if (bad[4]) report($sformatf("center_y %0d", center_y));
			if (bad[3]) report($sformatf("heading %0d", heading));
			if (bad[2]) report($sformatf("vel_x %0d", vel_x));
			if (bad[1]) report($sformatf("vel_y %0d", vel_y));
			if (bad[0]) report($sformatf("yaw_rate %0d", yaw_rate));
		end
		if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if ($urandom_range(99) < 4) begin
			pop_hold <= $urandom_range(300, 20);
			pop <= 1'b0;
		end else if ($urandom_range(99) < 25) begin
			pop_hold <= $urandom_range(3, 1);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send(swo_pkg::cmd_t cmd, logic [1:0] w, logic signed [23:0] spd,
			logic signed [15:0] ang, logic [19:0] dt, int gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command <= cmd;
		wheel_index <= w;
		wheel_speed <= spd;
		steer_angle <= ang;
		elapsed_time <= dt;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sb.note_item(cmd, w, spd, ang, dt);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(250, 20);
	endfunction

	// idle point: every pose has come back and the engine has drained
	task automatic drain_and_configure(logic [17:0] w);
		push <= 1'b0;
		@(posedge clk);
		while (sb.pose_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wdata <= w;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.configure(w);
	endtask

	task automatic random_items(int count);
		logic signed [23:0] spd;
		logic [19:0]        dt;
		for (int i = 0; i < count; i++) begin
			spd = $urandom_range(9, 0) == 0 ? 24'($urandom) : 24'($signed($urandom_range(262143)) - 131072);
			dt = $urandom_range(9, 0) == 0 ? 20'($urandom) : 20'($urandom_range(20000));
			if ($urandom_range(99) < 2) dt = '0;
			if ($urandom_range(4) == 0)
				send(swo_pkg::CMD_PUBLISH, 2'($urandom), 24'($urandom), 16'($urandom), dt,
					pick_gap());
			else
				send(swo_pkg::CMD_REPORT, 2'($urandom), spd, 16'($urandom), dt, pick_gap());
		end
	endtask

	initial begin
		sb = new();
		errors = 0;
		cycles = 0;
		pop_hold = 0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		command = swo_pkg::CMD_REPORT;
		wheel_index = '0;
		wheel_speed = '0;
		steer_angle = '0;
		elapsed_time = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pose straight after reset, with zero and full elapsed time
		send(swo_pkg::CMD_PUBLISH, 2'd0, '0, '0, '0, 0);
		send(swo_pkg::CMD_PUBLISH, 2'd3, 24'h7FFFFF, 16'h7FFF, 20'hFFFFF, 0);
		// every wheel, field extremes and steering past a right angle
		send(swo_pkg::CMD_REPORT, 2'd0, 24'sh7FFFFF, 16'sh7FFF, 20'hFFFFF, 0);
		send(swo_pkg::CMD_REPORT, 2'd1, -24'sh800000, -16'sh8000, 20'hFFFFF, 1);
		send(swo_pkg::CMD_REPORT, 2'd2, 24'sd65536, 16'sd12868, 20'd1048, 0);
		send(swo_pkg::CMD_REPORT, 2'd3, -24'sd65536, -16'sd12868, 20'd0, 0);
		send(swo_pkg::CMD_PUBLISH, 2'd0, '0, '0, 20'd1, 0);
		send(swo_pkg::CMD_REPORT, 2'd2, 24'sh7FFFFF, 16'sd25736, 20'hFFFFF, 0);
		send(swo_pkg::CMD_PUBLISH, 2'd2, '0, '0, 20'd1, 2);
		send(swo_pkg::CMD_PUBLISH, 2'd1, '0, '0, 20'd0, 0);
		random_items(150);

		// zero width: all corners at the center, zero vectors everywhere
		drain_and_configure(18'd0);
		send(swo_pkg::CMD_PUBLISH, 2'd0, '0, '0, 20'd1000, 0);
		send(swo_pkg::CMD_REPORT, 2'd0, 24'sd65536, 16'sd0, 20'd65536, 0);
		send(swo_pkg::CMD_PUBLISH, 2'd0, '0, '0, 20'd1000, 0);
		random_items(150);

		drain_and_configure(18'd1);
		random_items(150);
		drain_and_configure(18'h3FFFF);
		send(swo_pkg::CMD_PUBLISH, 2'd0, '0, '0, 20'd5, 0);
		random_items(150);
		drain_and_configure(18'($urandom_range(262143, 1)));
		random_items(180);

		push <= 1'b0;
		@(posedge clk);
		while (sb.pose_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
